[rtl/matrix4_inverse_macros.svh]
// Assertion macros shared by the matrix4_inverse RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MATRIX4_INVERSE_MACROS_SVH
`define MATRIX4_INVERSE_MACROS_SVH
`ifndef SYNTHESIS
// Flag a cycle where the condition holds.
`define M4I_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("m4i: forbidden condition");
// Same-cycle implication.
`define M4I_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("m4i: implication failed");
// Next-cycle implication.
`define M4I_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("m4i: next-cycle implication failed");
`else
`define M4I_NEVER(lbl, clk, rst, cond)
`define M4I_IMPLIES(lbl, clk, rst, ante, cons)
`define M4I_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/m4i_pkg.sv]
// Constants for the 4x4 matrix inverse: minor and cofactor schedules, phase codes.
// No dependencies.
`timescale 1ns / 1ps
package m4i_pkg;

  // Sequencer phases.
  localparam logic [1:0] PH_MINOR = 2'd0;
  localparam logic [1:0] PH_COF   = 2'd1;
  localparam logic [1:0] PH_DET   = 2'd2;
  localparam logic [1:0] PH_DIV   = 2'd3;

  localparam logic [4:0] LAST_MINOR = 5'd17;
  localparam logic [4:0] LAST_COF   = 5'd15;
  localparam logic [1:0] LAST_DET_TERM = 2'd3;

  // minor k = s[a]*s[b] - s[c]*s[d]
  localparam logic [3:0] MINOR_TAB [0:17][0:3] = '{
    '{4'd10, 4'd15, 4'd11, 4'd14}, '{4'd9, 4'd15, 4'd11, 4'd13},
    '{4'd9, 4'd14, 4'd10, 4'd13},  '{4'd8, 4'd15, 4'd11, 4'd12},
    '{4'd8, 4'd14, 4'd10, 4'd12},  '{4'd8, 4'd13, 4'd9, 4'd12},
    '{4'd6, 4'd15, 4'd7, 4'd14},   '{4'd5, 4'd15, 4'd7, 4'd13},
    '{4'd5, 4'd14, 4'd6, 4'd13},   '{4'd6, 4'd11, 4'd7, 4'd10},
    '{4'd5, 4'd11, 4'd7, 4'd9},    '{4'd5, 4'd10, 4'd6, 4'd9},
    '{4'd4, 4'd15, 4'd7, 4'd12},   '{4'd4, 4'd14, 4'd6, 4'd12},
    '{4'd4, 4'd11, 4'd7, 4'd8},    '{4'd4, 4'd10, 4'd6, 4'd8},
    '{4'd4, 4'd13, 4'd5, 4'd12},   '{4'd4, 4'd9, 4'd5, 4'd8}
  };

  // cofactor k = +/-(s[x]*M[p] - s[y]*M[q] + s[z]*M[r])
  localparam logic COF_NEG [0:15] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
  };
  localparam logic [3:0] COF_ELEM [0:15][0:2] = '{
    '{4'd5, 4'd6, 4'd7}, '{4'd1, 4'd2, 4'd3}, '{4'd1, 4'd2, 4'd3}, '{4'd1, 4'd2, 4'd3},
    '{4'd4, 4'd6, 4'd7}, '{4'd0, 4'd2, 4'd3}, '{4'd0, 4'd2, 4'd3}, '{4'd0, 4'd2, 4'd3},
    '{4'd4, 4'd5, 4'd7}, '{4'd0, 4'd1, 4'd3}, '{4'd0, 4'd1, 4'd3}, '{4'd0, 4'd1, 4'd3},
    '{4'd4, 4'd5, 4'd6}, '{4'd0, 4'd1, 4'd2}, '{4'd0, 4'd1, 4'd2}, '{4'd0, 4'd1, 4'd2}
  };
  localparam logic [4:0] COF_MINOR [0:15][0:2] = '{
    '{5'd0, 5'd1, 5'd2},   '{5'd0, 5'd1, 5'd2},   '{5'd6, 5'd7, 5'd8},
    '{5'd9, 5'd10, 5'd11}, '{5'd0, 5'd3, 5'd4},   '{5'd0, 5'd3, 5'd4},
    '{5'd6, 5'd12, 5'd13}, '{5'd9, 5'd14, 5'd15}, '{5'd1, 5'd3, 5'd5},
    '{5'd1, 5'd3, 5'd5},   '{5'd7, 5'd12, 5'd16}, '{5'd10, 5'd14, 5'd17},
    '{5'd2, 5'd4, 5'd5},   '{5'd2, 5'd4, 5'd5},   '{5'd8, 5'd13, 5'd16},
    '{5'd11, 5'd15, 5'd17}
  };

endpackage

[rtl/m4i_div.sv]
// Restoring bit-serial divider: saturated quotient of (num << 2F) / den.
// Standalone; instantiated by matrix4_inverse.
`timescale 1ns / 1ps
module m4i_div #(
  parameter int EW = 32,
  parameter int FB = 16,
  parameter int CW = 99,
  parameter int AW = 133
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] num,
  input  logic signed [AW-1:0] den,
  output logic                 done,
  output logic signed [EW-1:0] quo
);
  localparam int NW = CW + 2 * FB;
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   n_sh;
  logic [AW-1:0]   rem;
  logic [AW-1:0]   den_mag;
  logic [EW-1:0]   q;
  logic            big;
  logic            neg;
  logic            active;
  logic [CNTW-1:0] cnt;
  logic [AW:0]     trial;
  logic [AW:0]     diff;
  logic            ge;
  logic [CW-1:0]   num_mag;

  assign num_mag = num[CW-1] ? CW'(-num) : CW'(num);
  assign trial = {rem, n_sh[NW-1]};
  assign diff  = trial - {1'b0, den_mag};
  assign ge    = !diff[AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active  <= 1'b1;
        cnt     <= '0;
        n_sh    <= {num_mag, {(2 * FB){1'b0}}};
        rem     <= '0;
        den_mag <= den[AW-1] ? AW'(-den) : AW'(den);
        neg     <= num[CW-1] ^ den[AW-1];
        q       <= '0;
        big     <= 1'b0;
      end else if (active) begin
        n_sh <= {n_sh[NW-2:0], 1'b0};
        rem  <= ge ? diff[AW-1:0] : trial[AW-1:0];
        q    <= {q[EW-2:0], ge};
        big  <= big | q[EW-1];
        cnt  <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Saturate to the signed EW range.
  always_comb begin
    if (neg) begin
      if (big || (q[EW-1] && (q[EW-2:0] != '0))) quo = {1'b1, {(EW-1){1'b0}}};
      else quo = -$signed(q);
    end else begin
      if (big || q[EW-1]) quo = {1'b0, {(EW-1){1'b1}}};
      else quo = $signed(q);
    end
  end
endmodule

[rtl/matrix4_inverse.sv]
// Top level of the 4x4 fixed-point matrix inverse by the adjugate.
// Depends on m4i_pkg, m4i_div and matrix4_inverse_macros.svh.
`timescale 1ns / 1ps
// Load sixteen Q16.16 elements in row-major order, one per start pulse while
// busy is low. After the sixteenth, busy stays high while the block works
// out 18 minors, 16 cofactors and the determinant on one bit-serial
// multiply-accumulate unit (88 products), then divides each cofactor on
// one restoring divider that takes one quotient bit per cycle
// (3*EW+3+2*FRACTION_BITS steps). A singular matrix skips the divides.
// The sixteen results come out one per entry, each on the result ports for
// exactly one cycle with result_valid high; the receiver cannot stall them,
// so sample every result_valid cycle. last_result marks entry 15; singular
// is high on all sixteen when the determinant is zero, with zero values.
module matrix4_inverse #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] element_value,
  output logic               result_valid,
  output logic signed [31:0] result_value,
  output logic [3:0]         result_index,
  output logic               last_result,
  output logic               singular
);
  localparam int EW = ELEMENT_WIDTH;
  localparam int MW = 2 * EW + 1;       // minor width
  localparam int CW = 3 * EW + 3;       // cofactor width
  localparam int AW = 4 * EW + 5;       // accumulator / determinant width
  localparam int BW = $clog2(EW);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DFETCH = 3'd4;
  localparam logic [2:0] S_DLOAD  = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state;
  logic [3:0] load_count;
  logic [1:0] phase;
  logic [4:0] k;
  logic [1:0] t;
  logic [BW-1:0] bitcnt;

  // Storage
  logic [EW-1:0] elem_mem [0:15];
  logic [MW-1:0] mn_mem   [0:17];
  logic [CW-1:0] cof_mem  [0:15];
  logic [EW-1:0] elem_rd_a;
  logic [EW-1:0] elem_rd_b;
  logic [MW-1:0] mn_rd;
  logic [CW-1:0] cof_rd;

  // Multiply-accumulate datapath
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_next;
  logic [AW-1:0]        mcand;
  logic [EW-1:0]        mplier;
  logic                 op_sub;
  logic                 op_last;
  logic signed [AW-1:0] det;
  logic                 det_zero;
  logic                 term_neg;

  // Decoded operation
  logic [3:0] dec_a;
  logic [3:0] dec_b;
  logic [4:0] dec_mn;
  logic [3:0] cof_addr;
  logic       dec_sub;
  logic       dec_first;
  logic       dec_last;
  logic       mul_end;

  logic                 div_start;
  logic                 div_done;
  logic signed [EW-1:0] div_quo;

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_EMIT);
  assign det_zero     = (det == '0);
  assign mul_end      = (state == S_MUL) && (bitcnt == BW'(EW - 1));

  // Decode the current operation from phase, entry and term.
  always_comb begin
    dec_a     = '0;
    dec_b     = '0;
    dec_mn    = '0;
    dec_sub   = 1'b0;
    dec_first = (t == 2'd0);
    dec_last  = 1'b0;
    unique case (phase)
      m4i_pkg::PH_MINOR: begin
        dec_a    = m4i_pkg::MINOR_TAB[k][{t[0], 1'b0}];
        dec_b    = m4i_pkg::MINOR_TAB[k][{t[0], 1'b1}];
        dec_sub  = t[0];
        dec_last = t[0];
      end
      m4i_pkg::PH_COF: begin
        dec_b    = m4i_pkg::COF_ELEM[k[3:0]][t];
        dec_mn   = m4i_pkg::COF_MINOR[k[3:0]][t];
        dec_sub  = (t == 2'd1) ^ m4i_pkg::COF_NEG[k[3:0]];
        dec_last = (t == 2'd2);
      end
      m4i_pkg::PH_DET: begin
        dec_b    = {2'b00, t};
        dec_last = (t == m4i_pkg::LAST_DET_TERM);
      end
      default: begin
        dec_last = 1'b0;
      end
    endcase
  end

  assign cof_addr = (phase == m4i_pkg::PH_DET) ? {t, 2'b00} : k[3:0];

  // One partial product per cycle; the sign bit of the multiplier weighs negative.
  assign term_neg = op_sub ^ (bitcnt == BW'(EW - 1));
  assign acc_next = mplier[0] ? (acc + $signed(term_neg ? ~mcand : mcand)
                                 + $signed(AW'(term_neg))) : acc;

  // Registered memory reads.
  always_ff @(posedge clk) begin
    elem_rd_a <= elem_mem[dec_a];
    elem_rd_b <= elem_mem[dec_b];
    mn_rd     <= mn_mem[dec_mn];
    cof_rd    <= cof_mem[cof_addr];
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      elem_mem[load_count] <= element_value[EW-1:0];
    end
    if (mul_end && op_last && (phase == m4i_pkg::PH_MINOR)) begin
      mn_mem[k] <= acc_next[MW-1:0];
    end
    if (mul_end && op_last && (phase == m4i_pkg::PH_COF)) begin
      cof_mem[k[3:0]] <= acc_next[CW-1:0];
    end
  end

  assign div_start = (state == S_DLOAD) && !det_zero;

  m4i_div #(
    .EW(EW),
    .FB(FRACTION_BITS),
    .CW(CW),
    .AW(AW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  ($signed(cof_rd)),
    .den  (det),
    .done (div_done),
    .quo  (div_quo)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_count <= '0;
      phase      <= m4i_pkg::PH_MINOR;
      k          <= '0;
      t          <= '0;
      bitcnt     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            load_count <= load_count + 1'b1;
            if (load_count == 4'd15) begin
              state <= S_FETCH;
              phase <= m4i_pkg::PH_MINOR;
              k     <= '0;
              t     <= '0;
            end
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          // Pick the multiplicand source, sign-extended to the accumulator.
          unique case (phase)
            m4i_pkg::PH_MINOR: mcand <= AW'($signed(elem_rd_a));
            m4i_pkg::PH_COF:   mcand <= AW'($signed(mn_rd));
            default:           mcand <= AW'($signed(cof_rd));
          endcase
          mplier  <= elem_rd_b;
          op_sub  <= dec_sub;
          op_last <= dec_last;
          if (dec_first) acc <= '0;
          bitcnt  <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          acc    <= acc_next;
          mcand  <= {mcand[AW-2:0], 1'b0};
          mplier <= {1'b0, mplier[EW-1:1]};
          bitcnt <= bitcnt + 1'b1;
          if (mul_end) begin
            state <= S_FETCH;
            if (!op_last) begin
              t <= t + 1'b1;
            end else begin
              t <= '0;
              priority if (phase == m4i_pkg::PH_MINOR && k == m4i_pkg::LAST_MINOR) begin
                phase <= m4i_pkg::PH_COF;
                k     <= '0;
              end else if (phase == m4i_pkg::PH_COF && k == m4i_pkg::LAST_COF) begin
                phase <= m4i_pkg::PH_DET;
                k     <= '0;
              end else if (phase == m4i_pkg::PH_DET) begin
                // Determinant done: hold it and move on to the divides.
                det   <= acc_next;
                phase <= m4i_pkg::PH_DIV;
                k     <= '0;
                state <= S_DFETCH;
              end else begin
                k <= k + 1'b1;
              end
            end
          end
        end
        S_DFETCH: begin
          state <= S_DLOAD;
        end
        S_DLOAD: begin
          if (det_zero) begin
            result_value <= '0;
            result_index <= k[3:0];
            last_result  <= (k == m4i_pkg::LAST_COF);
            singular     <= 1'b1;
            state        <= S_EMIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            result_value <= 32'(div_quo);
            result_index <= k[3:0];
            last_result  <= (k == m4i_pkg::LAST_COF);
            singular     <= 1'b0;
            state        <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Drop back to loading after the last entry.
          if (k == m4i_pkg::LAST_COF) begin
            state <= S_IDLE;
            phase <= m4i_pkg::PH_MINOR;
            k     <= '0;
          end else begin
            k     <= k + 1'b1;
            state <= S_DFETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "matrix4_inverse_macros.svh"
  `M4I_IMPLIES(a_emit_busy, clk, rst, result_valid, busy)
  `M4I_NEXT(a_last_idle, clk, rst, result_valid && last_result, !busy)
  `M4I_NEXT(a_partial_load, clk, rst, start && !busy && (load_count != 4'd15), !busy)
  `M4I_IMPLIES(a_singular_zero, clk, rst, result_valid && singular, result_value == '0)
  `M4I_IMPLIES(a_index_order, clk, rst, result_valid && last_result, result_index == 4'd15)

endmodule

[tb/sv/matrix4_inverse_tb.sv]
// Self-checking testbench for matrix4_inverse: loads 4x4 Q16.16 matrices and
// checks every inverse element against an exact adjugate predictor or typed results.
// Depends on m4i_pkg (minor and cofactor schedules) and the matrix4_inverse RTL.
`timescale 1ns / 1ps
module matrix4_inverse_tb;

  localparam int  FRAC       = 16;
  localparam int  N_RANDOM   = 14;        // random matrices after the table
  localparam int  CYCLE_CAP  = 1000000;
  localparam int  DRAIN_WAIT = 200;

  // How the results of one matrix are known: typed in, or worked out.
  typedef enum logic [1:0] {EXP_PREDICT, EXP_IDENTITY, EXP_SINGULAR} exp_kind_t;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        last;
    logic        sing;
  } inv_elem_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] element_value = '0;
  logic               result_valid;
  logic signed [31:0] result_value;
  logic [3:0]         result_index;
  logic               last_result;
  logic               singular;

  matrix4_inverse u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .element_value(element_value), .result_valid(result_valid),
    .result_value(result_value), .result_index(result_index),
    .last_result(last_result), .singular(singular)
  );

  always #1 clk = ~clk;

  // Shadow of the block: the loaded elements and the next slot.
  logic signed [31:0] shadow_store [0:15];
  logic [3:0]         shadow_slot;
  inv_elem_t          inverse_q [$];
  exp_kind_t          kind_q [$];
  int                 mismatches;
  int                 results_seen;
  int                 singular_seen;
  int                 cycle_count;

  // Directed table: identity, then a singular matrix of extremes (rows 0 and 1 equal).
  logic [31:0] directed_rows [0:31] = '{
    32'h0001_0000, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0001_0000, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0001_0000, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0001_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h5555_5555,
    32'hAAAA_AAAA, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001
  };
  exp_kind_t directed_kind [0:1] = '{EXP_IDENTITY, EXP_SINGULAR};

  // Exact inverse by the adjugate: minors, cofactors, determinant, then each
  // cofactor scaled by 2^(2F) over the determinant, truncated and saturated.
  task automatic push_inverse();
    logic signed [191:0] e [0:15];
    logic signed [191:0] minor [0:17];
    logic signed [191:0] cof [0:15];
    logic signed [191:0] det;
    logic signed [191:0] quo;
    inv_elem_t           item;
    for (int i = 0; i < 16; i++) e[i] = shadow_store[i];
    for (int k = 0; k < 18; k++)
      minor[k] = e[m4i_pkg::MINOR_TAB[k][0]] * e[m4i_pkg::MINOR_TAB[k][1]]
               - e[m4i_pkg::MINOR_TAB[k][2]] * e[m4i_pkg::MINOR_TAB[k][3]];
    for (int k = 0; k < 16; k++) begin
      cof[k] = e[m4i_pkg::COF_ELEM[k][0]] * minor[m4i_pkg::COF_MINOR[k][0]]
             - e[m4i_pkg::COF_ELEM[k][1]] * minor[m4i_pkg::COF_MINOR[k][1]]
             + e[m4i_pkg::COF_ELEM[k][2]] * minor[m4i_pkg::COF_MINOR[k][2]];
      if (m4i_pkg::COF_NEG[k]) cof[k] = -cof[k];
    end
    det = e[0] * cof[0] + e[1] * cof[4] + e[2] * cof[8] + e[3] * cof[12];
    for (int k = 0; k < 16; k++) begin
      item.index = k[3:0];
      item.last  = (k == 15);
      item.sing  = (det == 0);
      if (det == 0) begin
        item.value = '0;
      end else begin
        // SV signed divide truncates toward zero, as the block does.
        quo = (cof[k] <<< (2 * FRAC)) / det;
        if (quo > 192'sh7FFF_FFFF)        item.value = 32'h7FFF_FFFF;
        else if (quo < -192'sh8000_0000)  item.value = 32'h8000_0000;
        else                              item.value = quo[31:0];
      end
      inverse_q.push_back(item);
    end
  endtask

  // Typed results: identity inverts to itself, a singular matrix gives zeros.
  task automatic push_typed(input exp_kind_t kind);
    inv_elem_t item;
    for (int k = 0; k < 16; k++) begin
      item.index = k[3:0];
      item.last  = (k == 15);
      item.sing  = (kind == EXP_SINGULAR);
      item.value = (kind == EXP_IDENTITY && k % 5 == 0) ? 32'h0001_0000 : 32'h0;
      inverse_q.push_back(item);
    end
  endtask

  // Accept side: record each element transaction; the sixteenth closes the matrix.
  always @(posedge clk) begin
    exp_kind_t kind;
    if (rst) begin
      shadow_slot <= '0;
    end else if (start && !busy) begin
      shadow_store[shadow_slot] = element_value;
      shadow_slot <= shadow_slot + 4'd1;
      if (shadow_slot == 4'd15) begin
        kind = kind_q.pop_front();
        if (kind == EXP_PREDICT) push_inverse();
        else push_typed(kind);
      end
    end
  end

  // Result side: every strobe carries one transaction; compare with the oldest.
  always @(posedge clk) begin
    inv_elem_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && result_valid) begin
      results_seen <= results_seen + 1;
      if (singular) singular_seen <= singular_seen + 1;
      if (inverse_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("[%0d] unexpected result idx=%0d val=%h", cycle_count,
                   result_index, result_value);
      end else begin
        want = inverse_q.pop_front();
        if (want.value !== result_value || want.index !== result_index ||
            want.last !== last_result || want.sing !== singular) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display({"[%0d] mismatch exp idx=%0d val=%h last=%b sing=%b,",
                      " got idx=%0d val=%h last=%b sing=%b"},
                     cycle_count, want.index, want.value, want.last, want.sing,
                     result_index, result_value, last_result, singular);
        end
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               inverse_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle gap before an element: mostly none, sometimes short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one element transaction; start stays high across back-to-back items.
  task automatic send_element(input logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0 || busy) start <= 1'b0;
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1;
    element_value <= v;
    @(negedge clk);
  endtask

  // Random element in the style of one matrix class.
  function automatic logic [31:0] pick_element(input int style, input int pos);
    case (style)
      0: return $urandom();
      1: return (pos % 5 == 0) ? 32'($urandom_range(1, 8)) << FRAC
                               : 32'($signed($urandom_range(0, 65535)) - 32768);
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [31:0] mat [0:15];
    int          style;
    int          dup_row;
    mismatches    = 0;
    results_seen  = 0;
    singular_seen = 0;
    cycle_count   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table, one matrix at a time.
    for (int m = 0; m < 2; m++) begin
      kind_q.push_back(directed_kind[m]);
      for (int i = 0; i < 16; i++) send_element(directed_rows[16 * m + i]);
    end

    // Random matrices: general, well-conditioned, tiny (saturating or singular),
    // extremes, and some made singular by a repeated row.
    for (int m = 0; m < N_RANDOM; m++) begin
      style = $urandom_range(0, 3);
      for (int i = 0; i < 16; i++) mat[i] = pick_element(style, i);
      if ($urandom_range(0, 4) == 0) begin
        dup_row = $urandom_range(1, 3);
        for (int c = 0; c < 4; c++) mat[4 * dup_row + c] = mat[c];
      end
      kind_q.push_back(EXP_PREDICT);
      for (int i = 0; i < 16; i++) send_element(mat[i]);
    end
    start <= 1'b0;

    // Drain: all results in, then a short settle.
    while (inverse_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d matrices (%0d elements), %0d results, %0d singular",
             2 + N_RANDOM, 16 * (2 + N_RANDOM), results_seen, singular_seen);
    $display("mismatches: %0d in %0d cycles", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[matrix4_inverse.f]
+incdir+rtl
rtl/m4i_pkg.sv
rtl/m4i_div.sv
rtl/matrix4_inverse.sv
tb/sv/matrix4_inverse_tb.sv
